// ===== sv/lspd_pkg.sv =====
// lspd_pkg: shared types, register codes, reset values and rounding helpers
// for the line sensor pd steering block. no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lspd_pkg;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // shared multiplier operand and product widths
    localparam int MUL_W  = 18;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 40;

    localparam logic [2:0] REG_LOWPASS_GAIN = 3'd0;
    localparam logic [2:0] REG_PROP_GAIN    = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN   = 3'd2;
    localparam logic [2:0] REG_TURN_LIMIT   = 3'd3;
    localparam logic [2:0] REG_CRUISE_SPEED = 3'd4;
    localparam logic [2:0] REG_SLOW_SCALE   = 3'd5;
    localparam logic [2:0] REG_LOST_HOLD    = 3'd6;

    localparam logic [15:0]        LOWPASS_GAIN_RST = 16'd19661;
    localparam logic signed [15:0] PROP_GAIN_RST    = 16'sd256;
    localparam logic signed [15:0] DERIV_GAIN_RST   = 16'sd0;
    localparam logic [14:0]        TURN_LIMIT_RST   = 15'd512;
    localparam logic [14:0]        CRUISE_SPEED_RST = 15'd256;
    localparam logic [15:0]        SLOW_SCALE_RST   = 16'd9362;
    localparam logic [7:0]         LOST_HOLD_RST    = 8'd10;

    // q0.16 constants: slowdown depth, falling and rising speed gains
    localparam logic signed [MUL_W-1:0] K_SLOW = 18'sd24904;
    localparam logic signed [MUL_W-1:0] K_FALL = 18'sd36045;
    localparam logic signed [MUL_W-1:0] K_RISE = 18'sd11796;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic signed [ACC_W-1:0] HALF_SH8  = 40'sd128;
    localparam logic signed [ACC_W-1:0] HALF_SH16 = 40'sd32768;

    typedef struct packed {
        logic [15:0]        lowpass_gain;
        logic signed [15:0] prop_gain;
        logic signed [15:0] deriv_gain;
        logic [14:0]        turn_limit;
        logic [14:0]        cruise_speed;
        logic [15:0]        slow_scale;
        logic [7:0]         lost_hold_ticks;
    } lspd_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV_SETUP,
        ST_DIV,
        ST_LP_MUL,
        ST_LP_ADD,
        ST_PD_P,
        ST_PD_D,
        ST_PD_SUM,
        ST_SL,
        ST_FACT_MUL,
        ST_FACT,
        ST_TGT_MUL,
        ST_TGT,
        ST_SM_MUL,
        ST_SM_ADD
    } lspd_state_t;

    // round to nearest, ties toward +inf
    function automatic logic signed [ACC_W-1:0] rnd_shr8(input logic signed [ACC_W-1:0] v);
        return (v + HALF_SH8) >>> 8;
    endfunction

    function automatic logic signed [ACC_W-1:0] rnd_shr16(input logic signed [ACC_W-1:0] v);
        return (v + HALF_SH16) >>> 16;
    endfunction

endpackage

`default_nettype wire

// ===== sv/lspd_regs.sv =====
// lspd_regs: apb-style configuration register file for the steering block
// depends on lspd_pkg for the register codes, reset values and cfg struct
`timescale 1ns / 1ps
`default_nettype none

module lspd_regs
    import lspd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output lspd_cfg_t         cfg
);

    lspd_cfg_t  cfg_reg;
    lspd_cfg_t  cfg_next;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[APB_AW-1:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_LOWPASS_GAIN: cfg_next.lowpass_gain    = pwdata[15:0];
                REG_PROP_GAIN:    cfg_next.prop_gain       = pwdata[15:0];
                REG_DERIV_GAIN:   cfg_next.deriv_gain      = pwdata[15:0];
                REG_TURN_LIMIT:   cfg_next.turn_limit      = pwdata[14:0];
                REG_CRUISE_SPEED: cfg_next.cruise_speed    = pwdata[14:0];
                REG_SLOW_SCALE:   cfg_next.slow_scale      = pwdata[15:0];
                REG_LOST_HOLD:    cfg_next.lost_hold_ticks = pwdata[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lowpass_gain    <= LOWPASS_GAIN_RST;
            cfg_reg.prop_gain       <= PROP_GAIN_RST;
            cfg_reg.deriv_gain      <= DERIV_GAIN_RST;
            cfg_reg.turn_limit      <= TURN_LIMIT_RST;
            cfg_reg.cruise_speed    <= CRUISE_SPEED_RST;
            cfg_reg.slow_scale      <= SLOW_SCALE_RST;
            cfg_reg.lost_hold_ticks <= LOST_HOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_LOWPASS_GAIN: prdata = {16'h0000, cfg_reg.lowpass_gain};
            REG_PROP_GAIN:    prdata = {16'h0000, cfg_reg.prop_gain};
            REG_DERIV_GAIN:   prdata = {16'h0000, cfg_reg.deriv_gain};
            REG_TURN_LIMIT:   prdata = {17'h00000, cfg_reg.turn_limit};
            REG_CRUISE_SPEED: prdata = {17'h00000, cfg_reg.cruise_speed};
            REG_SLOW_SCALE:   prdata = {16'h0000, cfg_reg.slow_scale};
            REG_LOST_HOLD:    prdata = {24'h000000, cfg_reg.lost_hold_ticks};
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/line_sensor_pd_steering.sv =====
// line_sensor_pd_steering: centroid, low-pass, pd turn law and speed smoothing
// depends on lspd_pkg and lspd_regs
//
//  port group   dir   signals                                    beat
//  in           in    in_valid, in_stall, sensor_byte            one sensor reading
//  out          out   out_valid, out_stall, fwd_speed,           one command
//                     turn_rate, line_error
//  cfg          in    psel, penable, pwrite, paddr, pwdata,      one register write
//                     prdata, pready
//
// 8 sensors: scan of each sensor in turn, divider setup, 14 quotient bits, 12 steps around the shared
// 18x18 multiplier; the result loads and the block returns to idle, where the next reading is taken
// seven or more sensors on the line skip the divider, a lost line skips scan, divide and
// the low-pass step; in_stall stays high until the result loads
// a waiting result holds under out_stall while the next reading is worked on
// reset restores register defaults and clears filter, history and hold count
`timescale 1ns / 1ps
`default_nettype none

module line_sensor_pd_steering
    import lspd_pkg::*;
#(
    parameter int SENSOR_COUNT = 8
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         sensor_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [14:0]        fwd_speed,
    output logic signed [15:0] turn_rate,
    output logic signed [11:0] line_error,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam int IDX_W = $clog2(SENSOR_COUNT);
    localparam int CNT_W = $clog2(SENSOR_COUNT + 1);
    localparam int SUM_W = $clog2(SENSOR_COUNT * SENSOR_COUNT / 4 + 1) + 1;
    localparam int DVD_W = SUM_W + 8;
    localparam int DC_W  = $clog2(DVD_W);

    lspd_cfg_t   cfg;
    lspd_state_t state_reg, state_next;

    // control and filter state
    logic                     out_valid_reg, out_valid_next;
    logic signed [15:0]       filt_reg, filt_next;
    logic signed [15:0]       prev_reg, prev_next;
    logic [7:0]               lost_reg, lost_next;
    logic signed [15:0]       sm_reg, sm_next;

    // working registers
    logic [SENSOR_COUNT-1:0]  bits_reg, bits_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [DVD_W-1:0]         q_reg, q_next;
    logic [CNT_W-1:0]         rem_reg, rem_next;
    logic [DC_W-1:0]          dcnt_reg, dcnt_next;
    logic signed [15:0]       err_reg, err_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [PROD_W-1:0] mul_reg;
    logic signed [15:0]       turn_reg, turn_next;
    logic [16:0]              sl_reg, sl_next;
    logic [16:0]              factor_reg, factor_next;
    logic signed [15:0]       target_reg, target_next;
    logic [14:0]              fwd_out_reg, fwd_out_next;
    logic signed [15:0]       turn_out_reg, turn_out_next;
    logic signed [11:0]       lerr_out_reg, lerr_out_next;

    // shared multiplier
    logic                     mul_en;
    logic signed [MUL_W-1:0]  mul_a, mul_b;

    // combinational helpers
    logic [SENSOR_COUNT-1:0]  sens_in;
    logic                     line_lost;
    logic                     slot_free;
    logic signed [SUM_W-1:0]  weight;
    logic [SUM_W-1:0]         sum_mag;
    logic [CNT_W:0]           rem_shift;
    logic                     q_bit;
    logic [15:0]              q16;
    logic signed [16:0]       raw_err;
    logic signed [16:0]       err_mag;
    logic signed [ACC_W-1:0]  mul_rnd16, mul_rnd8;
    logic signed [ACC_W-1:0]  pd_sum, pd_w, lim;

    lspd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign fwd_speed  = fwd_out_reg;
    assign turn_rate  = turn_out_reg;
    assign line_error = lerr_out_reg;

    // sensors above the input byte read as on the line
    assign sens_in   = SENSOR_COUNT'(sensor_byte);
    assign line_lost = (sens_in == '0) || (sens_in == '1);
    assign slot_free = !out_valid_reg || !out_stall;

    assign weight  = SUM_W'($signed({1'b0, idx_reg, 1'b0})) - SUM_W'(SENSOR_COUNT - 1);
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    assign rem_shift = {rem_reg, q_reg[DVD_W-1]};
    assign q_bit     = (rem_shift >= {1'b0, cnt_reg});

    assign q16     = 16'(q_reg);
    assign raw_err = sum_reg[SUM_W-1] ? -$signed({1'b0, q16}) : $signed({1'b0, q16});
    assign err_mag = err_reg[15] ? -17'(err_reg) : 17'(err_reg);

    assign mul_rnd16 = rnd_shr16(ACC_W'(mul_reg));
    assign mul_rnd8  = rnd_shr8(ACC_W'(mul_reg));
    assign pd_sum    = ACC_W'(acc_reg) + ACC_W'(mul_reg);
    assign pd_w      = rnd_shr8(pd_sum);
    assign lim       = ACC_W'(cfg.turn_limit);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        filt_next      = filt_reg;
        prev_next      = prev_reg;
        lost_next      = lost_reg;
        sm_next        = sm_reg;
        bits_next      = bits_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        err_next       = err_reg;
        acc_next       = acc_reg;
        turn_next      = turn_reg;
        sl_next        = sl_reg;
        factor_next    = factor_reg;
        target_next    = target_reg;
        fwd_out_next   = fwd_out_reg;
        turn_out_next  = turn_out_reg;
        lerr_out_next  = lerr_out_reg;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (line_lost)
                    begin
                        if (lost_reg < cfg.lost_hold_ticks)
                        begin
                            lost_next = lost_reg + 8'd1;
                            err_next  = filt_reg;
                        end
                        else
                        begin
                            filt_next = '0;
                            prev_next = '0;
                            err_next  = '0;
                        end
                        state_next = ST_PD_P;
                    end
                    else
                    begin
                        lost_next  = '0;
                        bits_next  = sens_in;
                        idx_next   = '0;
                        sum_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (!bits_reg[0])
                begin
                    sum_next = sum_reg + weight;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                bits_next = bits_reg >> 1;
                idx_next  = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(SENSOR_COUNT - 1))
                begin
                    state_next = ST_DIV_SETUP;
                end
            end

            ST_DIV_SETUP:
            begin
                rem_next  = '0;
                dcnt_next = DC_W'(DVD_W - 1);
                if ((cnt_reg == '0) || (cnt_reg >= CNT_W'(SENSOR_COUNT - 1)))
                begin
                    q_next     = '0;
                    state_next = ST_LP_MUL;
                end
                else
                begin
                    // |sum| * 256 + cnt / 2, divided by cnt
                    q_next     = DVD_W'({sum_mag[SUM_W-2:0], 8'h00})
                               + DVD_W'(cnt_reg >> 1);
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                rem_next  = q_bit ? CNT_W'(rem_shift - {1'b0, cnt_reg})
                                  : CNT_W'(rem_shift);
                q_next    = {q_reg[DVD_W-2:0], q_bit};
                dcnt_next = dcnt_reg - DC_W'(1);
                if (dcnt_reg == '0)
                begin
                    state_next = ST_LP_MUL;
                end
            end

            ST_LP_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(raw_err) - MUL_W'(filt_reg);
                mul_b      = MUL_W'(cfg.lowpass_gain);
                state_next = ST_LP_ADD;
            end

            ST_LP_ADD:
            begin
                filt_next  = filt_reg + mul_rnd16[15:0];
                err_next   = filt_reg + mul_rnd16[15:0];
                state_next = ST_PD_P;
            end

            ST_PD_P:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(err_reg);
                mul_b      = MUL_W'(cfg.prop_gain);
                state_next = ST_PD_D;
            end

            ST_PD_D:
            begin
                acc_next   = mul_reg;
                mul_en     = 1'b1;
                mul_a      = MUL_W'(err_reg) - MUL_W'(prev_reg);
                mul_b      = MUL_W'(cfg.deriv_gain);
                state_next = ST_PD_SUM;
            end

            ST_PD_SUM:
            begin
                if (pd_w > lim)
                begin
                    turn_next = lim[15:0];
                end
                else if (pd_w < -lim)
                begin
                    turn_next = 16'(-lim);
                end
                else
                begin
                    turn_next = pd_w[15:0];
                end
                prev_next  = err_reg;
                mul_en     = 1'b1;
                mul_a      = MUL_W'(err_mag);
                mul_b      = MUL_W'(cfg.slow_scale);
                state_next = ST_SL;
            end

            ST_SL:
            begin
                // slowdown level saturates at 1.0
                if (mul_rnd8 > ACC_W'(ONE_Q16))
                begin
                    sl_next = ONE_Q16;
                end
                else
                begin
                    sl_next = mul_rnd8[16:0];
                end
                state_next = ST_FACT_MUL;
            end

            ST_FACT_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = K_SLOW;
                mul_b      = MUL_W'(sl_reg);
                state_next = ST_FACT;
            end

            ST_FACT:
            begin
                factor_next = ONE_Q16 - mul_rnd16[16:0];
                state_next  = ST_TGT_MUL;
            end

            ST_TGT_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(cfg.cruise_speed);
                mul_b      = MUL_W'(factor_reg);
                state_next = ST_TGT;
            end

            ST_TGT:
            begin
                target_next = mul_rnd16[15:0];
                state_next  = ST_SM_MUL;
            end

            ST_SM_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(target_reg) - MUL_W'(sm_reg);
                mul_b      = (target_reg < sm_reg) ? K_FALL : K_RISE;
                state_next = ST_SM_ADD;
            end

            ST_SM_ADD:
            begin
                // hold here until the output register has room
                if (slot_free)
                begin
                    sm_next        = sm_reg + mul_rnd16[15:0];
                    fwd_out_next   = 15'(sm_reg + mul_rnd16[15:0]);
                    turn_out_next  = turn_reg;
                    lerr_out_next  = err_reg[11:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            filt_reg      <= '0;
            prev_reg      <= '0;
            lost_reg      <= '0;
            sm_reg        <= 16'(CRUISE_SPEED_RST);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            filt_reg      <= filt_next;
            prev_reg      <= prev_next;
            lost_reg      <= lost_next;
            sm_reg        <= sm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg     <= bits_next;
        idx_reg      <= idx_next;
        sum_reg      <= sum_next;
        cnt_reg      <= cnt_next;
        q_reg        <= q_next;
        rem_reg      <= rem_next;
        dcnt_reg     <= dcnt_next;
        err_reg      <= err_next;
        acc_reg      <= acc_next;
        turn_reg     <= turn_next;
        sl_reg       <= sl_next;
        factor_reg   <= factor_next;
        target_reg   <= target_next;
        fwd_out_reg  <= fwd_out_next;
        turn_out_reg <= turn_out_next;
        lerr_out_reg <= lerr_out_next;
        if (mul_en)
        begin
            mul_reg <= mul_a * mul_b;
        end
    end

endmodule

`default_nettype wire
